FILE: rtl/train_speed_autopilot_top_defines.svh
// ---------------------------------------------------------------------------
// Train speed autopilot: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TRAIN_SPEED_AUTOPILOT_TOP_DEFINES_SVH
`define TRAIN_SPEED_AUTOPILOT_TOP_DEFINES_SVH

// Overlapping implication: the consequent must hold in the same cycle.
`define TSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication: the consequent must hold in the next cycle.
`define TSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tsa_pkg.sv
// ---------------------------------------------------------------------------
// Train speed autopilot package
// Task codes, item and state types, and the fixed thresholds of the driver.
// ---------------------------------------------------------------------------
package tsa_pkg;

  // Driver tasks; the code that is left over is never entered.
  typedef enum logic [2:0] {
    TASK_ACCEL     = 3'd0,
    TASK_COAST     = 3'd1,
    TASK_LIMIT     = 3'd2,
    TASK_SIGNAL    = 3'd3,
    TASK_STATION   = 3'd4,
    TASK_RECOVER   = 3'd5,
    TASK_PASSENGER = 3'd6
  } task_e;

  // Target speed after reset, in km/h.
  localparam logic [7:0] TARGET_RESET = 8'd100;

  // Speed margins around the target, in 1/16 km/h.
  localparam logic [13:0] MARGIN_32  = 14'd32;
  localparam logic [13:0] MARGIN_48  = 14'd48;
  localparam logic [13:0] MARGIN_80  = 14'd80;
  localparam logic [13:0] MARGIN_160 = 14'd160;

  // Low speed (20 km/h) below which a far stop releases the brake.
  localparam logic [12:0] SPEED_LOW = 13'd320;

  // Distances in metres.
  localparam logic [15:0] DIST_200  = 16'd200;
  localparam logic [15:0] DIST_500  = 16'd500;
  localparam logic [15:0] DIST_700  = 16'd700;
  localparam logic [15:0] DIST_1000 = 16'd1000;
  localparam logic [15:0] DIST_1300 = 16'd1300;

  // Station approach: dist * 16 < speed * 75 + 16000.
  localparam logic [20:0] STN_GAIN   = 21'd75;
  localparam logic [20:0] STN_OFFSET = 21'd16000;
  // Signal approach: dist * 16 < (speed - limit) * 150.
  localparam logic [20:0] SIG_GAIN   = 21'd150;

  // Brake factor thresholds: speed_q4 * dist against factor * 16000.
  localparam logic [28:0] BF_50  = 29'd800000;
  localparam logic [28:0] BF_100 = 29'd1600000;
  localparam logic [28:0] BF_150 = 29'd2400000;
  localparam logic [28:0] BF_200 = 29'd3200000;
  localparam logic [28:0] BF_250 = 29'd4000000;
  localparam logic [28:0] BF_400 = 29'd6400000;
  localparam logic [28:0] BF_800 = 29'd12800000;

  // Driver state carried from tick to tick.
  typedef struct packed {
    task_e       task_cur;
    logic [7:0]  target;
    logic [2:0]  power;
    logic [2:0]  brake;
  } tsa_state_t;

  // One input item.
  typedef struct packed {
    logic [12:0] speed_q4;
    logic        overspeed_flag;
    logic        doors_open;
    logic        at_station;
    logic        emergency_active;
    logic        has_next_signal;
    logic [7:0]  next_signal_limit;
    logic        next_signal_red;
    logic [8:0]  prev_signal_limit;
    logic [7:0]  line_limit;
    logic [15:0] dist_to_signal;
    logic [15:0] dist_to_station_end;
  } tsa_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0] power_notch;
    logic [2:0] brake_notch;
    logic       emergency_pulse;
    logic       door_cycle;
    task_e      task_now;
  } tsa_result_t;

endpackage

FILE: rtl/tsa_step.sv
// ---------------------------------------------------------------------------
// Train speed autopilot: tick logic
// Runs the current task on one item, then re-decides it unless a passenger
// stop starts or ends; next driver state and result item are combinational.
// ---------------------------------------------------------------------------
module tsa_step (
  input  tsa_pkg::tsa_state_t  state_i,
  input  tsa_pkg::tsa_item_t   item_i,
  output tsa_pkg::tsa_state_t  state_o,
  output tsa_pkg::tsa_result_t res_o
);

  logic [12:0]         s;
  logic [13:0]         s14;
  logic [13:0]         m14;
  logic [13:0]         mline14;
  logic [15:0]         dist_sel;
  logic [28:0]         bf;
  logic                emerg_out;
  logic                door_out;
  logic                redecide;
  tsa_pkg::tsa_state_t mid;
  tsa_pkg::tsa_state_t fin;
  logic [13:0]         mmid14;
  logic [20:0]         dst16;
  logic [20:0]         dsig16;
  logic [20:0]         stn_reach;
  logic                stn_near;
  logic [13:0]         nl14;
  logic [12:0]         over_nl;
  logic [20:0]         sig_reach;
  logic                lim_near;

  assign s       = item_i.speed_q4;
  assign s14     = {1'b0, s};
  assign m14     = {2'b00, state_i.target, 4'b0000};
  assign mline14 = {2'b00, item_i.line_limit, 4'b0000};

  // One multiplier serves both brake factors; the task picks the distance.
  assign dist_sel = (state_i.task_cur == tsa_pkg::TASK_SIGNAL) ? item_i.dist_to_signal
                                                              : item_i.dist_to_station_end;
  assign bf       = {16'd0, s} * {13'd0, dist_sel};

  // Task step: set the held notches and possibly the target and task.
  always_comb begin
    mid       = state_i;
    emerg_out = 1'b0;
    door_out  = 1'b0;
    redecide  = 1'b1;
    unique case (state_i.task_cur)
      tsa_pkg::TASK_ACCEL: begin
        mid.brake = 3'd0;
        if (item_i.overspeed_flag || (s14 + tsa_pkg::MARGIN_48 > m14)) begin
          mid.power    = 3'd0;
          mid.target   = item_i.prev_signal_limit[8] ? item_i.line_limit
                                                     : item_i.prev_signal_limit[7:0];
          mid.task_cur = tsa_pkg::TASK_COAST;
        end else if (!item_i.doors_open) begin
          mid.power = 3'd7;
        end
      end
      tsa_pkg::TASK_COAST: begin
        if (item_i.overspeed_flag || (s14 > m14 + tsa_pkg::MARGIN_80)) begin
          mid.task_cur = tsa_pkg::TASK_LIMIT;
        end else if (s14 > m14 + tsa_pkg::MARGIN_32) begin
          mid.brake = 3'd0;
          mid.power = 3'd0;
        end else if (s14 + tsa_pkg::MARGIN_32 < m14) begin
          mid.brake = 3'd0;
          mid.power = 3'd2;
        end
      end
      tsa_pkg::TASK_LIMIT: begin
        mid.power = 3'd0;
        if (s14 > m14 + tsa_pkg::MARGIN_160) begin
          mid.brake = 3'd3;
        end else if (s14 > m14 + tsa_pkg::MARGIN_80) begin
          mid.brake = 3'd2;
        end else if (s14 + tsa_pkg::MARGIN_48 > m14) begin
          mid.brake = 3'd1;
        end else if (s14 < m14) begin
          mid.brake = 3'd0;
        end
      end
      tsa_pkg::TASK_SIGNAL: begin
        mid.power = 3'd0;
        if (bf > tsa_pkg::BF_400) begin
          emerg_out = 1'b1;
        end else if (bf > tsa_pkg::BF_250) begin
          mid.brake = 3'd7;
        end else if (bf > tsa_pkg::BF_200) begin
          mid.brake = 3'd6;
        end else if (bf > tsa_pkg::BF_150) begin
          mid.brake = 3'd5;
        end else if (bf > tsa_pkg::BF_100) begin
          mid.brake = 3'd4;
        end else if ((s < tsa_pkg::SPEED_LOW) &&
                     (item_i.dist_to_signal > tsa_pkg::DIST_1300)) begin
          mid.brake = 3'd0;
        end else if ((s != 13'd0) && (item_i.dist_to_signal < tsa_pkg::DIST_1000)) begin
          mid.brake = 3'd2;
        end else begin
          mid.brake = 3'd3;
        end
      end
      tsa_pkg::TASK_STATION: begin
        mid.power = 3'd0;
        if ((s == 13'd0) && item_i.at_station) begin
          mid.task_cur = tsa_pkg::TASK_PASSENGER;
        end else if (bf > tsa_pkg::BF_800) begin
          emerg_out = 1'b1;
        end else if (bf > tsa_pkg::BF_400) begin
          mid.brake = 3'd7;
        end else if (bf > tsa_pkg::BF_200) begin
          mid.brake = 3'd6;
        end else if (bf > tsa_pkg::BF_150) begin
          mid.brake = 3'd5;
        end else if (bf > tsa_pkg::BF_100) begin
          mid.brake = 3'd4;
        end else if (bf > tsa_pkg::BF_50) begin
          mid.brake = 3'd3;
        end else if ((s < tsa_pkg::SPEED_LOW) &&
                     (item_i.dist_to_station_end > tsa_pkg::DIST_700)) begin
          mid.brake = 3'd0;
        end else if ((s != 13'd0) &&
                     (item_i.dist_to_station_end < tsa_pkg::DIST_500)) begin
          mid.brake = 3'd4;
        end else begin
          mid.brake = 3'd3;
        end
      end
      tsa_pkg::TASK_RECOVER: begin
        if (s == 13'd0) begin
          mid.brake = 3'd0;
        end
      end
      tsa_pkg::TASK_PASSENGER: begin
        door_out     = 1'b1;
        mid.task_cur = tsa_pkg::TASK_ACCEL;
        redecide     = 1'b0;
      end
      default: begin
        mid = state_i;
      end
    endcase
  end

  // Terms of the task decision. A decision run inside a task step gives the
  // same outcome as the one that follows it, so one decision suffices.
  assign mmid14    = {2'b00, mid.target, 4'b0000};
  assign dst16     = {1'b0, item_i.dist_to_station_end, 4'b0000};
  assign dsig16    = {1'b0, item_i.dist_to_signal, 4'b0000};
  assign stn_reach = ({8'd0, s} * tsa_pkg::STN_GAIN) + tsa_pkg::STN_OFFSET;
  assign stn_near  = (dst16 < stn_reach) && (item_i.dist_to_station_end > tsa_pkg::DIST_200);
  assign nl14      = {2'b00, item_i.next_signal_limit, 4'b0000};
  assign over_nl   = s - nl14[12:0];
  assign sig_reach = {8'd0, over_nl} * tsa_pkg::SIG_GAIN;
  assign lim_near  = (s14 > nl14 + tsa_pkg::MARGIN_80) && (dsig16 < sig_reach);

  // Task decision from signals, station, speed and status.
  always_comb begin
    fin = mid;
    if (redecide && (mid.task_cur != tsa_pkg::TASK_PASSENGER)) begin
      if (item_i.has_next_signal) begin
        fin.target = item_i.line_limit;
        if ((mid.task_cur == tsa_pkg::TASK_SIGNAL) && !item_i.next_signal_red) begin
          fin.task_cur = tsa_pkg::TASK_ACCEL;
        end else if (stn_near) begin
          fin.task_cur = tsa_pkg::TASK_STATION;
        end else if (item_i.next_signal_red) begin
          fin.target   = 8'd0;
          fin.task_cur = tsa_pkg::TASK_SIGNAL;
        end else if (lim_near) begin
          fin.target   = item_i.next_signal_limit;
          fin.task_cur = tsa_pkg::TASK_LIMIT;
        end else if (item_i.emergency_active) begin
          fin.task_cur = tsa_pkg::TASK_RECOVER;
        end else if (s14 + tsa_pkg::MARGIN_32 < mline14) begin
          fin.task_cur = tsa_pkg::TASK_ACCEL;
        end else begin
          fin.task_cur = tsa_pkg::TASK_COAST;
        end
      end else begin
        if (item_i.emergency_active) begin
          fin.task_cur = tsa_pkg::TASK_RECOVER;
        end else if ((s == 13'd0) && !item_i.doors_open) begin
          fin.task_cur = tsa_pkg::TASK_ACCEL;
        end else if ((s14 > mmid14 + tsa_pkg::MARGIN_80) || item_i.overspeed_flag) begin
          fin.task_cur = tsa_pkg::TASK_LIMIT;
        end else begin
          fin.task_cur = tsa_pkg::TASK_ACCEL;
        end
      end
    end
  end

  assign state_o = fin;

  // Result item of this tick.
  assign res_o.power_notch     = fin.power;
  assign res_o.brake_notch     = fin.brake;
  assign res_o.emergency_pulse = emerg_out;
  assign res_o.door_cycle      = door_out;
  assign res_o.task_now        = fin.task_cur;

endmodule

FILE: rtl/train_speed_autopilot_top.sv
// ---------------------------------------------------------------------------
// Train speed autopilot: top level
// Input register, tick logic and result register of the automatic driver.
// ---------------------------------------------------------------------------
// The block takes one control tick per item and can accept a new item in
// every clock cycle unless a full result register is stalled. An item is
// captured in the input register at its accepting edge. Once the result
// register is free, the tick logic processes it (one speed times distance
// multiply and a set of compares), and the result is written to the result
// register, from which it is presented. The driver state is updated at the
// same edge, so the next item always sees the state left by the previous
// one. The target speed register may be written only while no item is in
// flight; the write also reloads the current target.

`include "train_speed_autopilot_top_defines.svh"

module train_speed_autopilot_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [12:0] speed_q4_i,
  input  logic        overspeed_flag_i,
  input  logic        doors_open_i,
  input  logic        at_station_i,
  input  logic        emergency_active_i,
  input  logic        has_next_signal_i,
  input  logic [7:0]  next_signal_limit_i,
  input  logic        next_signal_red_i,
  input  logic [8:0]  prev_signal_limit_i,
  input  logic [7:0]  line_limit_i,
  input  logic [15:0] dist_to_signal_i,
  input  logic [15:0] dist_to_station_end_i,
  // Result item channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  power_notch_o,
  output logic [2:0]  brake_notch_o,
  output logic        emergency_pulse_o,
  output logic        door_cycle_o,
  output logic [2:0]  task_now_o,
  // Configuration write channel (initial target speed)
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic                 in_accept;
  logic                 proc;
  logic                 cfg_we;
  logic                 in_valid_d;
  logic                 in_valid_q;
  logic                 out_valid_d;
  logic                 out_valid_q;
  tsa_pkg::tsa_item_t   item_d;
  tsa_pkg::tsa_item_t   item_q;
  tsa_pkg::tsa_state_t  state_d;
  tsa_pkg::tsa_state_t  state_q;
  tsa_pkg::tsa_state_t  state_step;
  tsa_pkg::tsa_result_t res_step;
  tsa_pkg::tsa_result_t res_q;

  // Handshake: the held item moves on when the result register is free.
  assign proc        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !proc;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !in_valid_q && !out_valid_q;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign in_valid_d  = in_accept || (in_valid_q && !proc);
  assign out_valid_d = proc || (out_valid_q && out_stall_i);

  // Gather the input fields into one item.
  always_comb begin
    item_d.speed_q4            = speed_q4_i;
    item_d.overspeed_flag      = overspeed_flag_i;
    item_d.doors_open          = doors_open_i;
    item_d.at_station          = at_station_i;
    item_d.emergency_active    = emergency_active_i;
    item_d.has_next_signal     = has_next_signal_i;
    item_d.next_signal_limit   = next_signal_limit_i;
    item_d.next_signal_red     = next_signal_red_i;
    item_d.prev_signal_limit   = prev_signal_limit_i;
    item_d.line_limit          = line_limit_i;
    item_d.dist_to_signal      = dist_to_signal_i;
    item_d.dist_to_station_end = dist_to_station_end_i;
  end

  // Tick logic.
  tsa_step u_step (
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_step),
    .res_o   (res_step)
  );

  // Next driver state: a configuration write reloads the target.
  always_comb begin
    state_d = state_q;
    if (cfg_we) begin
      state_d.target = cfg_data_i;
    end else if (proc) begin
      state_d = state_step;
    end
  end

  // Control and driver state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      state_q.task_cur <= tsa_pkg::TASK_ACCEL;
      state_q.target   <= tsa_pkg::TARGET_RESET;
      state_q.power    <= 3'd0;
      state_q.brake    <= 3'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= item_d;
    end
    if (proc) begin
      res_q <= res_step;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign power_notch_o     = res_q.power_notch;
  assign brake_notch_o     = res_q.brake_notch;
  assign emergency_pulse_o = res_q.emergency_pulse;
  assign door_cycle_o      = res_q.door_cycle;
  assign task_now_o        = res_q.task_now;

  // A door cycle always hands the train back to the accelerate task.
  `TSA_ASSERT_IMP(a_door_to_accel, out_valid_q && res_q.door_cycle, res_q.task_now == tsa_pkg::TASK_ACCEL, "door cycle without return to accelerate")

  // An emergency request and a door cycle never come from the same tick.
  `TSA_ASSERT_IMP(a_emerg_door_excl, out_valid_q, !(res_q.emergency_pulse && res_q.door_cycle), "emergency pulse together with door cycle")

  // The input side stalls only behind a full, stalled result register.
  `TSA_ASSERT_IMP(a_stall_cause, in_stall_o, in_valid_q && out_valid_q && out_stall_i, "input stalled without a blocked result")

  // The driver state moves only on a processed item or a configuration write.
  `TSA_ASSERT_NXT(a_state_hold, !proc && !cfg_we, $stable(state_q), "driver state changed while idle")

  // A configuration write loads the target speed.
  `TSA_ASSERT_NXT(a_cfg_load, cfg_we, state_q.target == $past(cfg_data_i), "target not loaded by configuration write")

endmodule
